@@ rtl/core/etrc_pkg.sv @@
// Shared types and constants for the edge-trigger record capture block.
// No dependencies; imported by every module under rtl/core.
package etrc_pkg;

  // Record length in kept samples, and counter width to hold it
  localparam int RECORD_LENGTH = 200;
  localparam int CNT_W         = $clog2(RECORD_LENGTH + 1);

  // Register map
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_TRIGGER_LEVEL  = 1'b0;
  localparam logic REG_SAMPLE_DIVIDER = 1'b1;

  // Reset values of the registers
  localparam logic [7:0]  LEVEL_RESET   = 8'd105;
  localparam logic [15:0] DIVIDER_RESET = 16'd1;

  typedef struct packed {
    logic [7:0]  trigger_level;
    logic [15:0] sample_divider;
  } cfg_t;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] index;
    logic       triggered;
    logic       last;
  } result_t;

endpackage

@@ rtl/core/etrc_cfg_regs.sv @@
// APB-style configuration registers: trigger level and sample divider.
// Depends on etrc_pkg.
module etrc_cfg_regs
  import etrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes, decoded on the word address bit
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_level  <= LEVEL_RESET;
      cfg.sample_divider <= DIVIDER_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_TRIGGER_LEVEL:  cfg.trigger_level  <= pwdata[7:0];
        REG_SAMPLE_DIVIDER: cfg.sample_divider <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (paddr[2])
      REG_TRIGGER_LEVEL:  prdata = {24'd0, cfg.trigger_level};
      REG_SAMPLE_DIVIDER: prdata = {16'd0, cfg.sample_divider};
      default:            prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/etrc_capture.sv @@
// Decimation, trigger search and record capture state, one sample per transfer.
// Depends on etrc_pkg.
module etrc_capture
  import etrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] adc_sample,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  localparam int IDX_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] LEN      = CNT_W'(RECORD_LENGTH);
  localparam logic [CNT_W-1:0] LEN_LAST = CNT_W'(RECORD_LENGTH - 1);

  logic             capturing, capturing_next;
  logic             armed, armed_next;
  logic [CNT_W-1:0] search_count, search_count_next;
  logic [CNT_W-1:0] capture_count, capture_count_next;
  logic             record_triggered, record_triggered_next;
  logic [15:0]      divide_count, divide_count_next;

  logic [15:0]      div_eff;
  logic             keep;
  logic [CNT_W-1:0] search_inc;
  logic             trig_start, start, cap_last;
  logic [IDX_W-1:0] idx_wide;

  // divider of zero behaves as one
  assign div_eff    = (cfg.sample_divider == 16'd0) ? 16'd1 : cfg.sample_divider;
  assign keep       = ({1'b0, divide_count} + 17'd1) >= {1'b0, div_eff};
  assign search_inc = search_count + CNT_W'(1);
  assign trig_start = (adc_sample >= cfg.trigger_level) && armed;
  assign start      = trig_start || (search_inc >= LEN);
  assign cap_last   = capture_count >= LEN_LAST;
  assign idx_wide   = IDX_W'(capture_count);

  // next state and result
  always_comb begin
    capturing_next        = capturing;
    armed_next            = armed;
    search_count_next     = search_count;
    capture_count_next    = capture_count;
    record_triggered_next = record_triggered;
    divide_count_next     = divide_count;
    res_valid             = 1'b0;
    res.value             = adc_sample;
    res.index             = 8'd0;
    res.triggered         = record_triggered;
    res.last              = 1'b0;
    if (step) begin
      if (!keep) begin
        divide_count_next = divide_count + 16'd1;
      end else begin
        divide_count_next = 16'd0;
        if (!capturing) begin
          // search: below level arms, at/above level while armed fires
          if (adc_sample < cfg.trigger_level) begin
            armed_next = 1'b1;
          end else if (armed) begin
            armed_next = 1'b0;
          end
          if (start) begin
            search_count_next     = '0;
            capturing_next        = 1'b1;
            capture_count_next    = CNT_W'(1);
            record_triggered_next = trig_start;
            res_valid             = 1'b1;
            res.triggered         = trig_start;
          end else begin
            search_count_next = search_inc;
          end
        end else begin
          res_valid = 1'b1;
          res.index = idx_wide[7:0];
          res.last  = cap_last;
          if (cap_last) begin
            capturing_next     = 1'b0;
            capture_count_next = '0;
            search_count_next  = '0;
          end else begin
            capture_count_next = capture_count + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capturing        <= 1'b0;
      armed            <= 1'b0;
      search_count     <= '0;
      capture_count    <= '0;
      record_triggered <= 1'b0;
      divide_count     <= '0;
    end else begin
      capturing        <= capturing_next;
      armed            <= armed_next;
      search_count     <= search_count_next;
      capture_count    <= capture_count_next;
      record_triggered <= record_triggered_next;
      divide_count     <= divide_count_next;
    end
  end

  // capture count only runs during a record
  a_count_in_record: assert property (@(posedge clk) disable iff (rst)
    (capturing == (capture_count != '0)))
    else $error("capture count out of step with capturing flag");

  // search never runs past the record length
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (search_count < LEN))
    else $error("search count reached record length");

  // a record's final sample always ends the capture
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |=> !capturing)
    else $error("capture continued after final sample");

endmodule

@@ rtl/core/etrc_out_buf.sv @@
// Result register plus skid slot: input keeps flowing under stall until full.
// Depends on etrc_pkg.
module etrc_out_buf
  import etrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    main_free;

  assign room      = !skid_valid;
  assign main_free = !out_valid || out_ready;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (main_free) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

@@ rtl/core/edge_trigger_record_capture_core.sv @@
// Top level of the edge-trigger record capture block.
// Depends on etrc_pkg, etrc_cfg_regs, etrc_capture and etrc_out_buf.
//
//   channel  handshake                     payload
//   input    in_valid / in_ready           adc_sample
//   output   out_valid / out_ready         sample_value, sample_index,
//                                          was_triggered, last_of_record
//   config   psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One sample is taken per clock while in_ready is high. A result, made for a
// kept sample that starts or falls in a record, is registered in the output
// register, or in a skid slot behind it while the output stalls; in_ready
// drops only when both slots hold results. Reset is synchronous and returns
// the registers to level 105, divider 1, and the capture logic to searching.
module edge_trigger_record_capture_core
  import etrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        adc_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        sample_value,
  output logic [7:0]        sample_index,
  output logic              was_triggered,
  output logic              last_of_record,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign step = in_valid && in_ready;

  etrc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  etrc_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .adc_sample (adc_sample),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  etrc_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign sample_value   = out_data.value;
  assign sample_index   = out_data.index;
  assign was_triggered  = out_data.triggered;
  assign last_of_record = out_data.last;

endmodule
